/* sv/grc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and fixed-point constants for the grid raycast column unit.
// Depends on nothing; the top level and the testbench refer to it by scoped names.
package grc_pkg;

   localparam int FRAC      = 16;                 // fraction bits of all Q values
   localparam int POS_W     = 21;
   localparam int VEC_W     = 19;
   localparam int DIM_W     = 11;
   localparam int CAM_W     = 28;
   localparam int PROD_W    = VEC_W + CAM_W;
   localparam int RAY_W     = 32;
   localparam int DELTA_W   = 32;
   localparam int LINE_W    = 21;
   localparam int QUO_W     = 33;                 // holds 1.0 * 1.0 = 2^(2*FRAC)
   localparam int CODE_W    = 3;
   localparam int COL_W     = 10;
   localparam int CELL_W    = 5;
   localparam int DIST_W    = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(1) << (LINE_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_X    = 3'd0,
      CSR_POS_Y    = 3'd1,
      CSR_DIR_X    = 3'd2,
      CSR_DIR_Y    = 3'd3,
      CSR_PLANE_X  = 3'd4,
      CSR_PLANE_Y  = 3'd5,
      CSR_SCREEN_W = 3'd6,
      CSR_SCREEN_H = 3'd7
   } csr_index_type;

   typedef enum logic {
      CMD_WRITE_CELL = 1'b0,
      CMD_CAST       = 1'b1
   } command_type;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_CAM_DIV  = 11'b000_0000_0010,
      ST_RAY_MUL  = 11'b000_0000_0100,
      ST_RAY_ADD  = 11'b000_0000_1000,
      ST_DX_DIV   = 11'b000_0001_0000,
      ST_DY_DIV   = 11'b000_0010_0000,
      ST_SIDE_MUL = 11'b000_0100_0000,
      ST_STEP     = 11'b000_1000_0000,
      ST_CHECK    = 11'b001_0000_0000,
      ST_LINE_DIV = 11'b010_0000_0000,
      ST_FINISH   = 11'b100_0000_0000
   } state_type;

endpackage

/* sv/grc_divider.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Standalone; shared by every division of the raycast sequencer.
module grc_divider #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         num_in = numer;
         den_in = denom;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         num_in  = num_ff << 1;
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/grc_map_mem.sv */
`timescale 1ns / 1ps
// Map cell store: one write port, one registered read port, clearing sweep.
// Standalone; instantiated by the raycast column top level.
module grc_map_mem #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   output logic                     clear_busy
);

   localparam int AW = $clog2(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_ff;
   logic [AW:0]       clr_ff, clr_in;
   logic              busy;

   assign busy   = clr_ff != (AW + 1)'(DEPTH);
   assign clr_in = busy ? clr_ff + (AW + 1)'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_ff[AW-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data    = rd_ff;
   assign clear_busy = busy;

endmodule

/* sv/grid_raycast_column_unit.sv */
`timescale 1ns / 1ps
// Grid raycast column unit: map store, camera registers and DDA sequencer.
// Depends on grc_pkg, grc_divider and grc_map_mem.
//
//  channel | direction | transfer            | payload
//  --------+-----------+---------------------+------------------------------------
//  req_    | in        | tvalid & tready     | tuser command, tdata cell / column
//  rsp_    | out       | tvalid & tready     | tdata one column result
//  csr_    | in        | csr_we, no wait     | register index and value
//
// A cell write gives no transaction on rsp_. A cast runs up to four passes of the
// shared divider (camera x, both step sizes, line height, the last skipped when the
// wall distance is zero) plus setup states and, per grid step, ST_STEP and then
// ST_CHECK for the registered map read, for at most MAX_STEPS grid steps.
// After reset the map is swept to zero, one cell a cycle, and req_tready stays low
// until the sweep ends. A stalled result waits in the output register while the
// next request is accepted; a cast finishing behind it holds.
module grid_raycast_column_unit #(
   parameter int MAP_SIZE  = 32,
   parameter int MAX_STEPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // column[9:0], cell_x[14:10], cell_y[19:15],
                                    // cell_value[22:20], zero pad[23]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // out_column[9:0], draw_start[19:10],
                                    // draw_end[29:20], wall_code[32:30], hit_side[33],
                                    // wall_distance[57:34], red[65:58], green[73:66],
                                    // blue[81:74], zero pad[87:82]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [20:0] csr_wdata
);

   localparam int FRAC   = grc_pkg::FRAC;
   localparam int DEPTH  = MAP_SIZE * MAP_SIZE;
   localparam int AW     = $clog2(DEPTH);
   localparam int MAXC   = (MAP_SIZE > 32) ? MAP_SIZE : 32;
   localparam int MW     = $clog2(MAXC + 1) + 1;
   localparam int SD_W   = 34 + $clog2(MAX_STEPS);
   localparam int N_W    = $clog2(MAX_STEPS + 1);
   localparam int QUO_W  = grc_pkg::QUO_W;
   localparam int DEN_W  = SD_W;

   // ---------------------------------------------------------------- registers
   logic [grc_pkg::POS_W-1:0]        pos_x_ff, pos_y_ff;
   logic signed [grc_pkg::VEC_W-1:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [grc_pkg::DIM_W-1:0]        width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 21'd1441792;
         pos_y_ff   <= 21'd786432;
         dir_x_ff   <= -19'sd65536;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 19'sd43254;
         width_ff   <= 11'd640;
         height_ff  <= 11'd480;
      end else if (csr_we) begin
         case (grc_pkg::csr_index_type'(csr_index))
            grc_pkg::CSR_POS_X:    pos_x_ff   <= csr_wdata;
            grc_pkg::CSR_POS_Y:    pos_y_ff   <= csr_wdata;
            grc_pkg::CSR_DIR_X:    dir_x_ff   <= csr_wdata[18:0];
            grc_pkg::CSR_DIR_Y:    dir_y_ff   <= csr_wdata[18:0];
            grc_pkg::CSR_PLANE_X:  plane_x_ff <= csr_wdata[18:0];
            grc_pkg::CSR_PLANE_Y:  plane_y_ff <= csr_wdata[18:0];
            grc_pkg::CSR_SCREEN_W: width_ff   <= csr_wdata[10:0];
            grc_pkg::CSR_SCREEN_H: height_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- request fields
   logic [9:0] req_column;
   logic [4:0] req_cell_x, req_cell_y;
   logic [2:0] req_cell_value;
   logic       req_fire;

   assign req_column     = req_tdata[9:0];
   assign req_cell_x     = req_tdata[14:10];
   assign req_cell_y     = req_tdata[19:15];
   assign req_cell_value = req_tdata[22:20];
   assign req_fire       = req_tvalid && req_tready;

   // ---------------------------------------------------------------- map store
   logic          map_we, clear_busy;
   logic [AW-1:0] map_waddr, map_raddr;
   logic [2:0]    map_rdata;

   assign map_we = req_fire && (grc_pkg::command_type'(req_tuser) == grc_pkg::CMD_WRITE_CELL)
                   && (32'(req_cell_x) < MAP_SIZE) && (32'(req_cell_y) < MAP_SIZE);
   assign map_waddr = AW'(req_cell_x) * AW'(MAP_SIZE) + AW'(req_cell_y);

   grc_map_mem #(.DEPTH(DEPTH), .DATA_W(grc_pkg::CODE_W)) u_map (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (map_we),
      .wr_addr    (map_waddr),
      .wr_data    (req_cell_value),
      .rd_addr    (map_raddr),
      .rd_data    (map_rdata),
      .clear_busy (clear_busy)
   );

   // ---------------------------------------------------------------- divider
   logic             div_start_ff, div_start_in, div_done;
   logic [QUO_W-1:0] div_num_ff, div_num_in, div_quo;
   logic [DEN_W-1:0] div_den_ff, div_den_in;

   grc_divider #(.NUM_W(QUO_W), .DEN_W(DEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .numer    (div_num_ff),
      .denom    (div_den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------- cast datapath
   grc_pkg::state_type state_ff, state_in;

   logic [9:0]                         col_ff, col_in;
   logic [grc_pkg::DIM_W-1:0]          h_ff, h_in;
   logic signed [grc_pkg::CAM_W-1:0]   cam_ff, cam_in;
   logic signed [grc_pkg::PROD_W-1:0]  prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic signed [grc_pkg::RAY_W-1:0]   ray_x, ray_y;
   logic [grc_pkg::RAY_W-1:0]          abs_y_ff, abs_y_in;
   logic                               neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [grc_pkg::DELTA_W-1:0]        dx_ff, dx_in, dy_ff, dy_in, delta_sat;
   logic [SD_W-1:0]                    sx_ff, sx_in, sy_ff, sy_in, dist_ff, dist_in;
   logic signed [MW-1:0]               mx_ff, mx_in, my_ff, my_in, mx_nx, my_nx;
   logic [N_W-1:0]                     n_ff, n_in;
   logic                               side_ff, side_in, step_x, in_map;
   logic [2:0]                         code_ff, code_in;
   logic [grc_pkg::LINE_W-1:0]         line_ff, line_in;
   logic [16:0]                        term_x, term_y;
   logic [48:0]                        side_x_prod, side_y_prod;
   logic [9:0]                         half_h;
   logic [19:0]                        half_l;
   logic signed [21:0]                 start_s;
   logic [20:0]                        end_s;
   logic [10:0]                        end_c;
   logic [9:0]                         draw_start, draw_end;
   logic [7:0]                         red, green, blue;
   logic                               rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [87:0]                        rsp_data_ff, rsp_data_in;

   // Ray from camera x; product is floored by the arithmetic shift.
   assign ray_x = grc_pkg::RAY_W'(dir_x_ff) + grc_pkg::RAY_W'(prod_x_ff >>> FRAC);
   assign ray_y = grc_pkg::RAY_W'(dir_y_ff) + grc_pkg::RAY_W'(prod_y_ff >>> FRAC);

   // Step size saturates; a zero component divides by one and saturates too.
   assign delta_sat = div_quo[QUO_W-1] ? '1 : div_quo[grc_pkg::DELTA_W-1:0];

   assign term_x = neg_x_ff ? {1'b0, pos_x_ff[FRAC-1:0]} : 17'h10000 - {1'b0, pos_x_ff[FRAC-1:0]};
   assign term_y = neg_y_ff ? {1'b0, pos_y_ff[FRAC-1:0]} : 17'h10000 - {1'b0, pos_y_ff[FRAC-1:0]};
   assign side_x_prod = 49'(term_x) * 49'(dx_ff);
   assign side_y_prod = 49'(term_y) * 49'(dy_ff);

   // One DDA step: advance the axis whose side distance is smaller.
   assign step_x = sx_ff < sy_ff;
   assign mx_nx  = !step_x ? mx_ff : (neg_x_ff ? mx_ff - MW'(1) : mx_ff + MW'(1));
   assign my_nx  = step_x ? my_ff : (neg_y_ff ? my_ff - MW'(1) : my_ff + MW'(1));
   assign in_map = (mx_nx >= 0) && (my_nx >= 0)
                   && (mx_nx < $signed(MW'(MAP_SIZE))) && (my_nx < $signed(MW'(MAP_SIZE)));
   assign map_raddr = AW'($unsigned(mx_nx)) * AW'(MAP_SIZE) + AW'($unsigned(my_nx));

   // Stripe span and colour from the final line height.
   assign half_h  = h_ff[10:1];
   assign half_l  = line_ff[20:1];
   assign start_s = $signed({12'd0, half_h}) - $signed({2'd0, half_l});
   assign end_s   = 21'(half_l) + 21'(half_h);
   assign end_c   = (end_s >= 21'(h_ff)) ? h_ff - 11'd1 : end_s[10:0];
   assign draw_start = start_s < 0 ? 10'd0 : (start_s > 22'sd1023 ? 10'd1023 : start_s[9:0]);
   assign draw_end   = end_c > 11'd1023 ? 10'd1023 : end_c[9:0];

   always_comb begin
      case (code_ff)
         3'd1:    {red, green, blue} = {8'd255, 8'd0,   8'd0};
         3'd2:    {red, green, blue} = {8'd0,   8'd255, 8'd0};
         3'd3:    {red, green, blue} = {8'd0,   8'd0,   8'd255};
         3'd4:    {red, green, blue} = {8'd255, 8'd255, 8'd255};
         default: {red, green, blue} = {8'd255, 8'd255, 8'd0};
      endcase
      if (side_ff) begin
         red   = red >> 1;
         green = green >> 1;
         blue  = blue >> 1;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      h_in         = h_ff;
      cam_in       = cam_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      abs_y_in     = abs_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      dist_in      = dist_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      n_in         = n_ff;
      side_in      = side_ff;
      code_in      = code_ff;
      line_in      = line_ff;
      div_start_in = 1'b0;
      div_num_in   = div_num_ff;
      div_den_in   = div_den_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         grc_pkg::ST_IDLE: begin
            if (req_fire && grc_pkg::command_type'(req_tuser) == grc_pkg::CMD_CAST) begin
               col_in       = req_column;
               h_in         = (height_ff == '0) ? 11'd1 : height_ff;
               div_num_in   = QUO_W'({req_column, 1'b0}) << FRAC;
               div_den_in   = (width_ff == '0) ? DEN_W'(1) : DEN_W'(width_ff);
               div_start_in = 1'b1;
               state_in     = grc_pkg::ST_CAM_DIV;
            end
         end
         grc_pkg::ST_CAM_DIV: begin
            if (div_done) begin
               cam_in   = $signed({1'b0, div_quo[26:0]}) - grc_pkg::CAM_W'(1 << FRAC);
               state_in = grc_pkg::ST_RAY_MUL;
            end
         end
         grc_pkg::ST_RAY_MUL: begin
            prod_x_in = grc_pkg::PROD_W'(plane_x_ff) * grc_pkg::PROD_W'(cam_ff);
            prod_y_in = grc_pkg::PROD_W'(plane_y_ff) * grc_pkg::PROD_W'(cam_ff);
            state_in  = grc_pkg::ST_RAY_ADD;
         end
         grc_pkg::ST_RAY_ADD: begin
            neg_x_in     = ray_x < 0;
            neg_y_in     = ray_y < 0;
            abs_y_in     = ray_y < 0 ? -ray_y : ray_y;
            div_num_in   = QUO_W'(1) << (2 * FRAC);
            div_den_in   = (ray_x == 0) ? DEN_W'(1)
                           : DEN_W'(ray_x < 0 ? -ray_x : ray_x);
            div_start_in = 1'b1;
            state_in     = grc_pkg::ST_DX_DIV;
         end
         grc_pkg::ST_DX_DIV: begin
            if (div_done) begin
               dx_in        = delta_sat;
               div_den_in   = (abs_y_ff == '0) ? DEN_W'(1) : DEN_W'(abs_y_ff);
               div_start_in = 1'b1;
               state_in     = grc_pkg::ST_DY_DIV;
            end
         end
         grc_pkg::ST_DY_DIV: begin
            if (div_done) begin
               dy_in    = delta_sat;
               state_in = grc_pkg::ST_SIDE_MUL;
            end
         end
         grc_pkg::ST_SIDE_MUL: begin
            sx_in    = SD_W'(side_x_prod[48:FRAC]);
            sy_in    = SD_W'(side_y_prod[48:FRAC]);
            mx_in    = MW'(pos_x_ff[grc_pkg::POS_W-1:FRAC]);
            my_in    = MW'(pos_y_ff[grc_pkg::POS_W-1:FRAC]);
            n_in     = '0;
            dist_in  = '0;
            side_in  = 1'b0;
            state_in = grc_pkg::ST_STEP;
         end
         grc_pkg::ST_STEP: begin
            // Issue the map read for the new cell; leave the map as a codeless hit.
            if (step_x) begin
               dist_in = sx_ff;
               sx_in   = sx_ff + SD_W'(dx_ff);
            end else begin
               dist_in = sy_ff;
               sy_in   = sy_ff + SD_W'(dy_ff);
            end
            side_in = !step_x;
            mx_in   = mx_nx;
            my_in   = my_nx;
            n_in    = n_ff + N_W'(1);
            if (in_map) begin
               state_in = grc_pkg::ST_CHECK;
            end else begin
               code_in  = '0;
               state_in = grc_pkg::ST_LINE_DIV;
            end
         end
         grc_pkg::ST_CHECK: begin
            code_in = map_rdata;
            if (map_rdata != '0 || n_ff == N_W'(MAX_STEPS)) begin
               state_in = grc_pkg::ST_LINE_DIV;
            end else begin
               state_in = grc_pkg::ST_STEP;
            end
         end
         grc_pkg::ST_LINE_DIV: begin
            // Entered once with dist latched; a zero dist skips the divide, else start, then hold until done.
            if (dist_ff == '0) begin
               line_in  = grc_pkg::LINE_MAX;
               state_in = grc_pkg::ST_FINISH;
            end else if (!div_start_ff && div_done) begin
               line_in  = (div_quo > QUO_W'(grc_pkg::LINE_MAX)) ? grc_pkg::LINE_MAX
                          : div_quo[grc_pkg::LINE_W-1:0];
               state_in = grc_pkg::ST_FINISH;
            end else if (n_ff != '0) begin
               div_num_in   = QUO_W'({h_ff, 16'd0});
               div_den_in   = dist_ff;
               div_start_in = 1'b1;
               n_in         = '0;
            end
         end
         grc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load    = 1'b1;
               rsp_data_in = {6'd0, blue, green, red,
                              (dist_ff > SD_W'(24'hFFFFFF)) ? 24'hFFFFFF : dist_ff[23:0],
                              side_ff, code_ff, draw_end, draw_start, col_ff};
               state_in    = grc_pkg::ST_IDLE;
            end
         end
         default: state_in = grc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      h_ff        <= h_in;
      cam_ff      <= cam_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      abs_y_ff    <= abs_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      dist_ff     <= dist_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      side_ff     <= side_in;
      code_ff     <= code_in;
      line_ff     <= line_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= grc_pkg::ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
      end
   end

   assign req_tready = (state_ff == grc_pkg::ST_IDLE) && !clear_busy;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- assertions
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready)
      else $error("request accepted during map clearing sweep");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= N_W'(MAX_STEPS))
      else $error("grid step count beyond limit");

   a_check_in_map: assert property (@(posedge clock) disable iff (reset)
      state_ff == grc_pkg::ST_CHECK |->
         (mx_ff >= 0 && my_ff >= 0 && mx_ff < $signed(MW'(MAP_SIZE))
          && my_ff < $signed(MW'(MAP_SIZE))))
      else $error("map read for a cell outside the map");

   a_div_start_waits: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> (state_ff == grc_pkg::ST_CAM_DIV || state_ff == grc_pkg::ST_DX_DIV
                        || state_ff == grc_pkg::ST_DY_DIV || state_ff == grc_pkg::ST_LINE_DIV))
      else $error("divider started outside a divide state");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grc_pkg::ST_FINISH && (!rsp_valid_ff || rsp_tready)) |=> rsp_tvalid)
      else $error("finished cast did not reach the output register");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for grid_raycast_column_unit: map writes and column casts
// are checked against an in-bench DDA predictor. Depends on grc_pkg and the RTL.
module tb_top;

   localparam int MAP_N       = 32;
   localparam int STEP_LIMIT  = 64;
   localparam int SETTLE      = 300;     // cycles a cast may still run after the last result
   localparam int STALL_LIMIT = 5000;    // cycles without any transaction before giving up
   localparam int LONG_HOLD   = 400;

   typedef struct {
      grc_pkg::command_type cmd;
      logic [9:0]  column;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
      logic [2:0]  cell_value;
   } ray_req_type;

   typedef struct {
      logic [9:0]  column;
      logic [9:0]  draw_start;
      logic [9:0]  draw_end;
      logic [2:0]  wall_code;
      logic        hit_side;
      logic [23:0] wall_distance;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } column_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // column[9:0], cell_x[14:10], cell_y[19:15],
                                  // cell_value[22:20], zero pad[23]
   logic        req_tuser = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;        // out_column[9:0], draw_start[19:10], draw_end[29:20],
                                  // wall_code[32:30], hit_side[33], wall_distance[57:34],
                                  // red[65:58], green[73:66], blue[81:74]
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [20:0] csr_wdata = '0;

   grid_raycast_column_unit dut (.*);

   // Predictor state: map copy and camera registers as the block should hold them.
   logic [2:0] map_copy [MAP_N*MAP_N];
   longint     cam_pos_x, cam_pos_y, cam_dir_x, cam_dir_y;
   longint     cam_plane_x, cam_plane_y, scr_w, scr_h;

   ray_req_type       req_items[$];        // transactions still to offer on req_
   column_result_type column_results[$];   // predicted casts not yet seen on rsp_
   int                fail_count = 0;
   logic              quiet = 1'b0;        // no idling in the closing phase
   int                results_seen = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Step length for one axis: 1.0 / |ray|, saturated.
   function automatic longint step_len(input longint ray);
      longint mag;
      longint q;
      mag = ray < 0 ? -ray : ray;
      if (mag == 0) return 64'hFFFF_FFFF;
      q = (longint'(1) << (2*grc_pkg::FRAC)) / mag;
      return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
   endfunction

   function automatic longint first_edge(input longint pos, input longint ray,
                                         input longint delta);
      longint frac;
      frac = pos & ((longint'(1) << grc_pkg::FRAC) - 1);
      if (ray < 0) return (frac * delta) >> grc_pkg::FRAC;
      return (((longint'(1) << grc_pkg::FRAC) - frac) * delta) >> grc_pkg::FRAC;
   endfunction

   // Walk the grid for one column and work out the stripe the block should return.
   function automatic column_result_type cast_column(input logic [9:0] col);
      column_result_type res;
      longint w, h, cam, rx, ry, dx, dy, sx, sy, mx, my, stx, sty, wall_dist, line, st, en;
      logic [2:0] code;
      logic side;
      logic [7:0] r, g, b;
      w = scr_w == 0 ? 1 : scr_w;
      h = scr_h == 0 ? 1 : scr_h;
      cam = ((longint'(col) * 2) << grc_pkg::FRAC) / w - (longint'(1) << grc_pkg::FRAC);
      rx = cam_dir_x + ((cam_plane_x * cam) >>> grc_pkg::FRAC);
      ry = cam_dir_y + ((cam_plane_y * cam) >>> grc_pkg::FRAC);
      dx = step_len(rx);
      dy = step_len(ry);
      sx = first_edge(cam_pos_x, rx, dx);
      sy = first_edge(cam_pos_y, ry, dy);
      mx = cam_pos_x >> grc_pkg::FRAC;
      my = cam_pos_y >> grc_pkg::FRAC;
      stx = rx < 0 ? -1 : 1;
      sty = ry < 0 ? -1 : 1;
      wall_dist = 0;
      code = '0;
      side = 1'b0;
      for (int n = 0; n < STEP_LIMIT; n++) begin
         if (sx < sy) begin
            wall_dist = sx; sx += dx; mx += stx; side = 1'b0;
         end else begin
            wall_dist = sy; sy += dy; my += sty; side = 1'b1;
         end
         if (mx < 0 || my < 0 || mx >= MAP_N || my >= MAP_N) begin
            code = '0;
            break;
         end
         code = map_copy[mx*MAP_N + my];
         if (code != 0) break;
      end
      if (wall_dist == 0) line = longint'(1) << 20;
      else begin
         line = (h << grc_pkg::FRAC) / wall_dist;
         if (line > (longint'(1) << 20)) line = longint'(1) << 20;
      end
      st = h/2 - line/2;
      if (st < 0) st = 0;
      en = line/2 + h/2;
      if (en >= h) en = h - 1;
      if (st > 1023) st = 1023;
      if (en > 1023) en = 1023;
      case (code)
         3'd1: begin r = 8'd255; g = 8'd0; b = 8'd0; end
         3'd2: begin r = 8'd0; g = 8'd255; b = 8'd0; end
         3'd3: begin r = 8'd0; g = 8'd0; b = 8'd255; end
         3'd4: begin r = 8'd255; g = 8'd255; b = 8'd255; end
         default: begin r = 8'd255; g = 8'd255; b = 8'd0; end
      endcase
      if (side) begin
         r = r >> 1; g = g >> 1; b = b >> 1;
      end
      res.column = col;
      res.draw_start = st[9:0];
      res.draw_end = en[9:0];
      res.wall_code = code;
      res.hit_side = side;
      res.wall_distance = wall_dist > 64'hFF_FFFF ? 24'hFF_FFFF : wall_dist[23:0];
      res.red = r;
      res.green = g;
      res.blue = b;
      return res;
   endfunction

   // Driver: offer queued transactions, with random gaps; predict on acceptance.
   ray_req_type on_bus;
   int          req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (on_bus.cmd == grc_pkg::CMD_WRITE_CELL)
               map_copy[on_bus.cell_x*MAP_N + on_bus.cell_y] = on_bus.cell_value;
            else
               column_results.push_back(cast_column(on_bus.column));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else if (req_items.size() > 0) begin
               on_bus = req_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= on_bus.cmd;
               req_tdata <= {1'b0, on_bus.cell_value, on_bus.cell_y, on_bus.cell_x,
                             on_bus.column};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: stall the result side at random, once for a long stretch, and check.
   int  rsp_hold = 0;
   logic long_hold_done = 1'b0;
   always @(posedge clock) begin
      column_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (column_results.size() == 0) begin
               $display("%0t: result with none expected, actual column %0d",
                        $time, rsp_tdata[9:0]);
               fail_count++;
            end else begin
               want = column_results.pop_front();
               check_field("out_column", want.column, rsp_tdata[9:0]);
               check_field("draw_start", want.draw_start, rsp_tdata[19:10]);
               check_field("draw_end", want.draw_end, rsp_tdata[29:20]);
               check_field("wall_code", want.wall_code, rsp_tdata[32:30]);
               check_field("hit_side", want.hit_side, rsp_tdata[33]);
               check_field("wall_distance", want.wall_distance, rsp_tdata[57:34]);
               check_field("red", want.red, rsp_tdata[65:58]);
               check_field("green", want.green, rsp_tdata[73:66]);
               check_field("blue", want.blue, rsp_tdata[81:74]);
            end
         end
         // Hold off long once casts are flowing, so the block backs up into req_.
         if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            rsp_hold = LONG_HOLD;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_hold = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles without any transaction.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic write_reg(input grc_pkg::csr_index_type idx, input longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[20:0];
      case (idx)
         grc_pkg::CSR_POS_X:    cam_pos_x = value & 21'h1F_FFFF;
         grc_pkg::CSR_POS_Y:    cam_pos_y = value & 21'h1F_FFFF;
         grc_pkg::CSR_DIR_X:    cam_dir_x = longint'($signed(value[18:0]));
         grc_pkg::CSR_DIR_Y:    cam_dir_y = longint'($signed(value[18:0]));
         grc_pkg::CSR_PLANE_X:  cam_plane_x = longint'($signed(value[18:0]));
         grc_pkg::CSR_PLANE_Y:  cam_plane_y = longint'($signed(value[18:0]));
         grc_pkg::CSR_SCREEN_W: scr_w = value & 11'h7FF;
         default:               scr_h = value & 11'h7FF;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until the block has drained, then let a cast that gives no sign finish.
   task automatic drain();
      while (req_items.size() > 0 || req_tvalid || column_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add_cell(input int x, input int y, input int v);
      ray_req_type it;
      it.cmd = grc_pkg::CMD_WRITE_CELL;
      it.column = 10'($urandom);
      it.cell_x = x[4:0];
      it.cell_y = y[4:0];
      it.cell_value = v[2:0];
      req_items.push_back(it);
   endtask

   task automatic add_cast(input int col);
      ray_req_type it;
      it.cmd = grc_pkg::CMD_CAST;
      it.column = col[9:0];
      it.cell_x = 5'($urandom);
      it.cell_y = 5'($urandom);
      it.cell_value = 3'($urandom);
      req_items.push_back(it);
   endtask

   function automatic longint rand_vec();
      case ($urandom_range(0, 4))
         0: return -131072;
         1: return 131072;
         2: return 0;
         default: return longint'($urandom_range(0, 262144)) - 131072;
      endcase
   endfunction

   // One random camera, then a phase of mostly casts into a randomly walled map.
   task automatic random_phase(input int count);
      write_reg(grc_pkg::CSR_POS_X, $urandom_range(0, 9) == 0
                ? $urandom_range(0, 21'h1F_FFFF) : $urandom_range(65536, 31*65536));
      write_reg(grc_pkg::CSR_POS_Y, $urandom_range(0, 9) == 0
                ? $urandom_range(0, 21'h1F_FFFF) : $urandom_range(65536, 31*65536));
      write_reg(grc_pkg::CSR_DIR_X, rand_vec());
      write_reg(grc_pkg::CSR_DIR_Y, rand_vec());
      write_reg(grc_pkg::CSR_PLANE_X, rand_vec());
      write_reg(grc_pkg::CSR_PLANE_Y, rand_vec());
      write_reg(grc_pkg::CSR_SCREEN_W,
                $urandom_range(0, 7) == 0 ? 1024 : $urandom_range(1, 1023));
      write_reg(grc_pkg::CSR_SCREEN_H,
                $urandom_range(0, 7) == 0 ? 1024 : $urandom_range(1, 1023));
      end_writes();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 3)
            add_cell($urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7));
         else
            add_cast($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(0, scr_w));
      end
      drain();
   endtask

   initial begin
      foreach (map_copy[i]) map_copy[i] = '0;
      cam_pos_x = 1441792; cam_pos_y = 786432;
      cam_dir_x = -65536;  cam_dir_y = 0;
      cam_plane_x = 0;     cam_plane_y = 43254;
      scr_w = 640;         scr_h = 480;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty map leaves through the edge, then walls of every code.
      add_cast(0);
      add_cast(320);
      add_cell(3, 12, 1);
      add_cell(3, 11, 2);
      add_cell(3, 13, 3);
      add_cell(3, 10, 4);
      add_cell(3, 14, 5);
      add_cell(31, 31, 7);
      add_cell(0, 0, 6);
      add_cast(0);
      add_cast(320);
      add_cast(639);
      add_cast(1023);
      add_cast(200);
      add_cast(450);
      drain();

      // Directed: zero x ray, integer position (zero distance), zero screen size.
      write_reg(grc_pkg::CSR_POS_X, 22 * 65536);
      write_reg(grc_pkg::CSR_POS_Y, 12 * 65536);
      write_reg(grc_pkg::CSR_DIR_X, 0);
      write_reg(grc_pkg::CSR_PLANE_X, 0);
      write_reg(grc_pkg::CSR_DIR_Y, -65536);
      write_reg(grc_pkg::CSR_PLANE_Y, 0);
      write_reg(grc_pkg::CSR_SCREEN_W, 0);
      write_reg(grc_pkg::CSR_SCREEN_H, 0);
      end_writes();
      add_cell(22, 11, 2);
      add_cast(0);
      add_cast(1);
      drain();

      // Directed: extreme camera, tallest screen, largest x position.
      write_reg(grc_pkg::CSR_POS_X, 21'h1F_FFFF);
      write_reg(grc_pkg::CSR_DIR_X, 131072);
      write_reg(grc_pkg::CSR_DIR_Y, -131072);
      write_reg(grc_pkg::CSR_PLANE_X, -131072);
      write_reg(grc_pkg::CSR_PLANE_Y, 131072);
      write_reg(grc_pkg::CSR_SCREEN_W, 1024);
      write_reg(grc_pkg::CSR_SCREEN_H, 1024);
      end_writes();
      add_cast(0);
      add_cast(1023);
      drain();
      write_reg(grc_pkg::CSR_POS_X, 5 * 65536 + 32768);
      write_reg(grc_pkg::CSR_POS_Y, 6 * 65536 + 1);
      end_writes();
      add_cell(4, 5, 3);
      add_cast(512);
      add_cast(0);
      drain();

      // Random: fill part of the map so most rays hit walls, then vary the camera.
      for (int i = 0; i < 120; i++)
         add_cell($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 7));
      drain();
      for (int p = 0; p < 6; p++) random_phase(80);
      quiet <= 1'b1;
      random_phase(60);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
